// ----- rtl/tcr_pkg.sv -----
`default_nettype none

package tcr_pkg;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 28;
  localparam int unsigned DELAY_W    = 28;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned DC_COEF_W  = 23;
  localparam int unsigned FRAC_COEF  = 23;
  localparam int unsigned LIN_FRAC   = 16;
  localparam int unsigned MUL_B_W    = 25;

  localparam logic [REG_IDX_W-1:0] REG_DELAY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LP_EN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LP_COEF  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DC_EN    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DC_COEF  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_AP_COEF  = 3'd7;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_ALLPASS = 2'd2;

  localparam logic [COEF_W-1:0]    ONE_COEF     = 24'h800000;
  localparam logic [DELAY_W-1:0]   DELAY_RST    = 28'h0C80000;
  localparam logic [COEF_W-1:0]    GAIN_RST     = 24'h8021A0;
  localparam logic [COEF_W-1:0]    LP_COEF_RST  = 24'h800000;
  localparam logic [DC_COEF_W-1:0] DC_COEF_RST  = 23'h7FA258;
  localparam logic [COEF_W-1:0]    AP_COEF_RST  = 24'h000000;
  localparam logic [31:0]          DELAY_MIN    = 32'h0000_8000;

endpackage

`default_nettype wire

// ----- rtl/tuned_comb_resonator.sv -----
// Feedback comb resonator with a fractional delay tap.
// Input samples arrive on sample_in_i under in_valid_i/in_ready_o, and each
// accepted transaction yields exactly one output transaction on sample_out_o
// under out_valid_o/out_ready_i. The block handles one sample at a time.
// From acceptance to out_valid_o, the feedback gain product is always formed,
// and the tap interpolation, the lowpass and the DC blocker products are added
// when used. One shared multiplier serves all of them and consumes one
// coefficient bit per cycle.
// A new sample is accepted only once the previous one has left its last step.
// The delay store is a single memory with one write and one registered read
// port; the linear mode reads two neighbors on consecutive cycles.
// After reset the block clears the delay store, one entry per cycle;
// in_ready_o stays low until that pass ends.
// Configuration writes are taken at any time, but only while no sample is in
// flight do they give defined results.
// A finished result waits in the output register while the receiver stalls;
// a new sample may be accepted meanwhile, and it holds in its last step
// until the output register is free.
`default_nettype none

module tuned_comb_resonator
  import tcr_pkg::*;
#(
  parameter int unsigned DELAY_DEPTH = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]         cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o
);

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned AW  = $clog2(DELAY_DEPTH);
  localparam int unsigned LW  = AW + 1;
  localparam int unsigned MA  = S + 2;
  localparam int unsigned MB  = MUL_B_W;
  localparam int unsigned P   = S + 27;
  localparam int unsigned CW  = $clog2(MB);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_LAG  = 4'd2;
  localparam logic [3:0] ST_RDA  = 4'd3;
  localparam logic [3:0] ST_RDB  = 4'd4;
  localparam logic [3:0] ST_RDC  = 4'd5;
  localparam logic [3:0] ST_TAPF = 4'd6;
  localparam logic [3:0] ST_FB   = 4'd7;
  localparam logic [3:0] ST_SUMS = 4'd8;
  localparam logic [3:0] ST_LPS  = 4'd9;
  localparam logic [3:0] ST_LPF  = 4'd10;
  localparam logic [3:0] ST_WR   = 4'd11;
  localparam logic [3:0] ST_DCF  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;
  localparam logic [3:0] ST_MUL  = 4'd14;

  function automatic logic signed [P-1:0] sx_f(input logic signed [S-1:0] v);
    return P'(v);
  endfunction

  function automatic logic signed [P-1:0] rnd_f(input logic signed [P-1:0] v,
                                                input int unsigned n);
    logic signed [P-1:0] t;
    t = v + (P'(1) <<< (n - 1));
    return t >>> n;
  endfunction

  function automatic logic signed [S-1:0] sat_f(input logic signed [P-1:0] v);
    logic signed [P-1:0] hi;
    logic signed [P-1:0] lo;
    hi = {{(P-S+1){1'b0}}, {(S-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[S-1:0];
    end else if (v < lo) begin
      return lo[S-1:0];
    end
    return v[S-1:0];
  endfunction

  logic [DELAY_W-1:0]         delay_q;
  logic signed [COEF_W-1:0]   gain_q;
  logic [1:0]                 mode_q;
  logic                       lp_en_q;
  logic [COEF_W-1:0]          lp_coeff_q;
  logic                       dc_en_q;
  logic [DC_COEF_W-1:0]       dc_coeff_q;
  logic signed [COEF_W-1:0]   ap_coeff_q;

  logic [3:0]                 state_q, state_d, nxt_q;
  logic [AW-1:0]              clr_q, wp_q, rp_q;
  logic [LW-1:0]              lag_q;
  logic [LIN_FRAC-1:0]        w_q;
  logic signed [S-1:0]        x_q, va_q, tap_q, wv_q, res_q, out_q;
  logic signed [S-1:0]        api_q, prev_tap_q, lp_mem_q, dc_x1_q, dc_y1_q;
  logic signed [S:0]          sum_q;
  logic                       out_valid_q;

  logic signed [MA-1:0]       mul_a_q;
  logic [MB-1:0]              mul_b_q;
  logic signed [P-1:0]        acc_q;
  logic [CW-1:0]              cnt_q;

  logic signed [S-1:0]        mem [DELAY_DEPTH];
  logic signed [S-1:0]        rdata_q;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [S-1:0]        mem_wdata;

  logic [31:0]                d_clamp;
  logic [31:0]                d_max;
  logic [16:0]                lag_base;
  logic [16:0]                lag_full;
  logic [LW-1:0]              rp_diff;
  logic [AW-1:0]              rp_cur;
  logic [AW-1:0]              rp_next;
  logic [COEF_W-1:0]          lc_eff;
  logic                       lp_act;
  logic signed [P-1:0]        mul_addend;
  logic signed [P-1:0]        sum_full;
  logic signed [P-1:0]        lp_diff;

  assign d_max = 32'(DELAY_DEPTH - 1) << 16;

  always_comb begin
    if (32'(delay_q) < DELAY_MIN) begin
      d_clamp = DELAY_MIN;
    end else if (32'(delay_q) > d_max) begin
      d_clamp = d_max;
    end else begin
      d_clamp = 32'(delay_q);
    end
    lag_base = {1'b0, d_clamp[31:16]} + 17'(d_clamp[15:0] != '0);
    lag_full = lag_base;
    if (mode_q == MODE_ALLPASS) begin
      lag_full = lag_base - 17'd1
               - 17'((d_clamp[15:0] != '0) && (d_clamp[15:0] < 16'h8000));
    end
  end

  always_comb begin
    rp_diff = LW'(wp_q) - lag_q;
    if (LW'(wp_q) < lag_q) begin
      rp_diff = rp_diff + LW'(DELAY_DEPTH);
    end
    rp_cur  = rp_diff[AW-1:0];
    rp_next = (rp_q == AW'(DELAY_DEPTH - 1)) ? '0 : rp_q + AW'(1);
  end

  assign lc_eff   = (lp_coeff_q > ONE_COEF) ? ONE_COEF : lp_coeff_q;
  assign lp_act   = lp_en_q && (lc_eff != ONE_COEF);
  assign sum_full = sx_f(x_q) + rnd_f(acc_q, FRAC_COEF);
  assign lp_diff  = P'(sum_q) - sx_f(lp_mem_q);

  always_comb begin
    if (!mul_b_q[MB-1]) begin
      mul_addend = '0;
    end else if (cnt_q == '0) begin
      mul_addend = -P'(mul_a_q);
    end else begin
      mul_addend = P'(mul_a_q);
    end
  end

  always_comb begin
    rd_addr = rp_q;
    if (state_q == ST_RDA) begin
      rd_addr = rp_cur;
    end else if (state_q == ST_RDB) begin
      rd_addr = rp_next;
    end
    mem_we    = (state_q == ST_CLR) || (state_q == ST_WR);
    mem_waddr = (state_q == ST_CLR) ? clr_q : wp_q;
    mem_wdata = (state_q == ST_CLR) ? '0 : wv_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_RST;
      gain_q     <= GAIN_RST;
      mode_q     <= MODE_LINEAR;
      lp_en_q    <= 1'b0;
      lp_coeff_q <= LP_COEF_RST;
      dc_en_q    <= 1'b1;
      dc_coeff_q <= DC_COEF_RST;
      ap_coeff_q <= AP_COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DELAY:   delay_q    <= cfg_wdata_i[DELAY_W-1:0];
        REG_GAIN:    gain_q     <= cfg_wdata_i[COEF_W-1:0];
        REG_MODE:    mode_q     <= cfg_wdata_i[1:0];
        REG_LP_EN:   lp_en_q    <= cfg_wdata_i[0];
        REG_LP_COEF: lp_coeff_q <= cfg_wdata_i[COEF_W-1:0];
        REG_DC_EN:   dc_en_q    <= cfg_wdata_i[0];
        REG_DC_COEF: dc_coeff_q <= cfg_wdata_i[DC_COEF_W-1:0];
        REG_AP_COEF: ap_coeff_q <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_q == AW'(DELAY_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_LAG;
      ST_LAG:  state_d = ST_RDA;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_RDC;
      ST_RDC:  begin
        if (mode_q == MODE_LINEAR || mode_q == MODE_ALLPASS) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_FB;
        end
      end
      ST_TAPF: state_d = ST_FB;
      ST_FB:   state_d = ST_MUL;
      ST_SUMS: state_d = ST_LPS;
      ST_LPS:  state_d = lp_act ? ST_MUL : ST_WR;
      ST_LPF:  state_d = ST_WR;
      ST_WR:   state_d = dc_en_q ? ST_MUL : ST_OUT;
      ST_DCF:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      ST_MUL:  if (cnt_q == CW'(MB - 1)) state_d = nxt_q;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      api_q       <= '0;
      prev_tap_q  <= '0;
      lp_mem_q    <= '0;
      dc_x1_q     <= '0;
      dc_y1_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_TAPF: begin
          if (mode_q == MODE_ALLPASS) begin
            api_q <= va_q;
          end
        end
        ST_LPF: lp_mem_q <= sat_f(sx_f(lp_mem_q) + rnd_f(acc_q, FRAC_COEF));
        ST_WR: begin
          wp_q       <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
          prev_tap_q <= tap_q;
        end
        ST_DCF: begin
          dc_x1_q <= tap_q;
          dc_y1_q <= sat_f(sx_f(tap_q) - sx_f(dc_x1_q) + rnd_f(acc_q, FRAC_COEF));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) x_q <= sample_in_i;
      ST_LAG: begin
        lag_q <= lag_full[LW-1:0];
        w_q   <= (d_clamp[15:0] == '0) ? '0 : 16'(17'h10000 - 17'(d_clamp[15:0]));
      end
      ST_RDA: rp_q <= rp_cur;
      ST_RDB: va_q <= rdata_q;
      ST_RDC: begin
        acc_q <= '0;
        cnt_q <= '0;
        nxt_q <= ST_TAPF;
        if (mode_q == MODE_LINEAR) begin
          mul_a_q <= MA'(rdata_q) - MA'(va_q);
          mul_b_q <= MB'(w_q);
        end else if (mode_q == MODE_ALLPASS) begin
          mul_a_q <= MA'(va_q) - MA'(prev_tap_q);
          mul_b_q <= MB'(ap_coeff_q);
        end else if (mode_q == MODE_NONE) begin
          tap_q <= va_q;
        end else begin
          tap_q <= '0;
        end
      end
      ST_TAPF: begin
        if (mode_q == MODE_LINEAR) begin
          tap_q <= sat_f(sx_f(va_q) + rnd_f(acc_q, LIN_FRAC));
        end else begin
          tap_q <= sat_f(sx_f(api_q) + rnd_f(acc_q, FRAC_COEF));
        end
      end
      ST_FB: begin
        acc_q   <= '0;
        cnt_q   <= '0;
        nxt_q   <= ST_SUMS;
        mul_a_q <= MA'(tap_q);
        mul_b_q <= MB'(gain_q);
      end
      ST_SUMS: sum_q <= sum_full[S:0];
      ST_LPS: begin
        acc_q   <= '0;
        cnt_q   <= '0;
        nxt_q   <= ST_LPF;
        mul_a_q <= lp_diff[MA-1:0];
        mul_b_q <= MB'({1'b0, lc_eff});
        if (!lp_act) begin
          wv_q <= sat_f(P'(sum_q));
        end
      end
      ST_LPF: wv_q <= sat_f(sx_f(lp_mem_q) + rnd_f(acc_q, FRAC_COEF));
      ST_WR: begin
        acc_q   <= '0;
        cnt_q   <= '0;
        nxt_q   <= ST_DCF;
        mul_a_q <= MA'(dc_y1_q);
        mul_b_q <= MB'({2'b00, dc_coeff_q});
        res_q   <= tap_q;
      end
      ST_DCF: res_q <= sat_f(sx_f(tap_q) - sx_f(dc_x1_q) + rnd_f(acc_q, FRAC_COEF));
      ST_OUT: if (!out_valid_q || out_ready_i) out_q <= res_q;
      ST_MUL: begin
        acc_q   <= (acc_q <<< 1) + mul_addend;
        mul_b_q <= mul_b_q << 1;
        cnt_q   <= cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

`default_nettype wire

// ----- sim/tuned_comb_resonator_test.sv -----
`default_nettype none

module tuned_comb_resonator_test;
  import tcr_pkg::*;

  localparam int DEPTH = 4096;
  localparam int LIMIT = 2_000_000;

  class resonator_scoreboard;
    logic signed [23:0] ring [DEPTH];
    logic [11:0] wr_ptr;
    logic signed [23:0] ap_prev_in, prev_tap, lp_mem, dc_x1, dc_y1;
    logic [27:0] delay;
    logic signed [23:0] gain, ap_coef;
    logic [1:0] mode;
    logic lp_en, dc_en;
    logic [23:0] lp_coef;
    logic [22:0] dc_coef;
    logic signed [23:0] pending [$];
    int errors;
    int checked;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = '0;
      ap_prev_in = '0;
      prev_tap = '0;
      lp_mem = '0;
      dc_x1 = '0;
      dc_y1 = '0;
      delay = DELAY_RST;
      gain = GAIN_RST;
      mode = MODE_LINEAR;
      lp_en = 1'b0;
      lp_coef = LP_COEF_RST;
      dc_en = 1'b1;
      dc_coef = DC_COEF_RST;
      ap_coef = AP_COEF_RST;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [27:0] val);
      case (idx)
        REG_DELAY: delay = val;
        REG_GAIN: gain = val[23:0];
        REG_MODE: mode = val[1:0];
        REG_LP_EN: lp_en = val[0];
        REG_LP_COEF: lp_coef = val[23:0];
        REG_DC_EN: dc_en = val[0];
        REG_DC_COEF: dc_coef = val[22:0];
        REG_AP_COEF: ap_coef = val[23:0];
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clip(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function void note_input(logic signed [23:0] x);
      longint d, tap, a, b, w, v, sum, wv, y, lc;
      int di, f, lag;
      logic [11:0] rp;
      d = delay;
      if (d < 32768) d = 32768;
      if (d > (longint'(DEPTH - 1) << 16)) d = longint'(DEPTH - 1) << 16;
      di = int'(d >> 16);
      f = int'(d & 16'hFFFF);
      tap = 0;
      if (mode == MODE_NONE || mode == MODE_LINEAR) begin
        lag = di + (f != 0 ? 1 : 0);
        rp = wr_ptr - 12'(lag);
        tap = ring[rp];
        if (mode == MODE_LINEAR) begin
          b = ring[12'(rp + 12'd1)];
          w = (f != 0) ? 65536 - f : 0;
          tap = clip(tap + round_shift((b - tap) * w, 16));
        end
      end else if (mode == MODE_ALLPASS) begin
        a = ap_coef;
        lag = di + (f != 0 ? 1 : 0) - 1;
        if (f != 0 && f < 32768) lag = lag - 1;
        rp = wr_ptr - 12'(lag);
        v = ring[rp];
        tap = clip(ap_prev_in + round_shift(a * (v - prev_tap), 23));
        ap_prev_in = 24'(v);
      end
      sum = longint'(x) + round_shift(tap * longint'(gain), 23);
      lc = lp_coef;
      if (lc > 8388608) lc = 8388608;
      if (lp_en && lc != 8388608) begin
        wv = clip(lp_mem + round_shift(lc * (sum - lp_mem), 23));
        lp_mem = 24'(wv);
      end else begin
        wv = clip(sum);
      end
      ring[wr_ptr] = 24'(wv);
      wr_ptr = wr_ptr + 12'd1;
      prev_tap = 24'(tap);
      if (dc_en) begin
        y = clip(tap - dc_x1 + round_shift(longint'(dc_coef) * dc_y1, 23));
        dc_x1 = 24'(tap);
        dc_y1 = 24'(y);
      end else begin
        y = tap;
      end
      pending.push_back(24'(y));
    endfunction

    function void check_output(logic signed [23:0] got);
      logic signed [23:0] want;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, expected none, actual %0d", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic signed [23:0] sample_in_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  logic signed [23:0] sample_out_o;

  resonator_scoreboard board;
  int cycles = 0;
  int sent = 0;
  bit stalling = 1'b0;

  tuned_comb_resonator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .sample_in_i,
    .out_valid_o, .out_ready_i, .sample_out_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) board.note_input(sample_in_i);
    if (out_valid_o && out_ready_i) board.check_output(sample_out_o);
  end

  function int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  initial begin
    int g;
    board = new();
    @(negedge clk_i);
    forever begin
      if (stalling) begin
        out_ready_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        g = gap_length();
        if (g > 0) begin
          out_ready_i <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  task automatic send_sample(logic signed [23:0] x, bit bursty);
    int g;
    g = bursty ? gap_length() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    sample_in_i <= '0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [27:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
  endtask

  function logic signed [23:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($signed($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_settings(bit extreme);
    logic [27:0] dly;
    case ($urandom_range(0, 5))
      0: dly = 28'($urandom_range(0, 32768));
      1: dly = 28'($urandom_range(32768, 20 << 16));
      2: dly = 28'h0FF_FFFF + 28'($urandom_range(0, 28'hF00_0000));
      3: dly = 28'($urandom_range(1, 64)) << 16;
      default: dly = 28'($urandom_range(32768, 300 << 16));
    endcase
    write_cfg(REG_DELAY, dly);
    write_cfg(REG_GAIN, extreme ? ($urandom_range(0, 1) ? 28'h7FFFFF : 28'h800000)
                                : 28'($urandom) & 28'hFFFFFF);
    write_cfg(REG_MODE, 28'($urandom_range(0, 3)));
    write_cfg(REG_LP_EN, 28'($urandom_range(0, 1)));
    write_cfg(REG_LP_COEF, $urandom_range(0, 3) == 0 ? 28'($urandom) & 28'hFFFFFF
                                                      : 28'($urandom_range(0, 8388608)));
    write_cfg(REG_DC_EN, 28'($urandom_range(0, 1)));
    write_cfg(REG_DC_COEF, extreme ? 28'h7FFFFF : 28'($urandom) & 28'h7FFFFF);
    write_cfg(REG_AP_COEF, extreme ? ($urandom_range(0, 1) ? 28'h7FFFFF : 28'h800000)
                                   : 28'($urandom) & 28'hFFFFFF);
  endtask

  initial begin
    int phase;
    int n;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, field extremes, then every tap mode and corner.
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b0);
    send_sample(24'sh000000, 1'b0);
    send_sample(24'sh555555, 1'b0);
    wait_drained();
    write_cfg(REG_DELAY, 28'd0);
    write_cfg(REG_GAIN, 28'h7FFFFF);
    write_cfg(REG_MODE, 28'(MODE_NONE));
    write_cfg(REG_LP_EN, 28'd1);
    write_cfg(REG_LP_COEF, 28'hFFFFFF);
    write_cfg(REG_DC_EN, 28'd0);
    write_cfg(REG_DC_COEF, 28'h7FFFFF);
    write_cfg(REG_AP_COEF, 28'h800000);
    repeat (4) send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh2AAAAB, 1'b0);
    wait_drained();
    write_cfg(REG_MODE, 28'(MODE_ALLPASS));
    write_cfg(REG_DELAY, 28'h001_4000);
    write_cfg(REG_LP_COEF, 28'd1000);
    repeat (4) send_sample(-24'sh800000, 1'b0);
    wait_drained();
    write_cfg(REG_MODE, 28'd3);
    write_cfg(REG_DELAY, 28'hFFF_FFFF);
    write_cfg(REG_DC_EN, 28'd1);
    repeat (3) send_sample(24'sh400000, 1'b0);
    wait_drained();
    write_cfg(REG_MODE, 28'(MODE_LINEAR));
    write_cfg(REG_DELAY, 28'h002_C000);
    write_cfg(REG_LP_COEF, 28'h800000);
    write_cfg(REG_GAIN, 28'h800000);
    repeat (4) send_sample(24'sh7FFFFF, 1'b0);
    wait_drained();

    // Back-pressure: receiver holds off while the sender keeps offering.
    stalling = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        stalling = 1'b0;
      end
      repeat (6) send_sample(random_sample(), 1'b0);
    join
    wait_drained();

    for (phase = 0; phase < 12; phase++) begin
      random_settings(phase % 4 == 0);
      n = 120 + $urandom_range(0, 20);
      repeat (n) send_sample(random_sample(), $urandom_range(0, 2) != 0);
      wait_drained();
    end

    $display("Ran %0d samples over 12 random register settings plus directed corners;",
             sent);
    $display("%0d output transactions checked, covering all tap modes and filters.",
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
